>>> sv/cbd_pkg.sv
// shared types, constants and helpers of the cell balance decider
package cbd_pkg;

    localparam int MAX_CELLS = 256;
    localparam int GRP_SIZE  = 16;
    localparam int NUM_GRP   = (MAX_CELLS + GRP_SIZE - 1) / GRP_SIZE;
    localparam int MAP_IDX_W = $clog2(MAX_CELLS);
    // cell index compare width: one bit above the 8-bit count and cell number
    localparam int CMP_W     = 9;

    localparam logic [7:0] BALANCE_STATE = 8'd11;
    localparam logic [3:0] BASE_SHIFT    = 4'd2;

    // register indexes of the configuration port
    localparam logic [7:0] REG_CELL_COUNT    = 8'd0;
    localparam logic [7:0] REG_BALANCE_DELTA = 8'd1;
    localparam logic [7:0] REG_START_LEVEL   = 8'd2;
    localparam logic [7:0] REG_CHARGING_MODE = 8'd3;

    localparam logic FUNC_REPORT = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    typedef struct packed {
        logic [7:0]         cell_count;
        logic signed [15:0] balance_delta;
        logic signed [15:0] start_level;
        logic               charging;
        logic [3:0]         avg_shift;
    } t_cfg;

    typedef struct packed {
        logic               func;
        logic [7:0]         cell_num;
        logic [7:0]         cell_state;
        logic signed [15:0] cell_voltage;
    } t_item;

    typedef struct packed {
        logic       balance_on;
        logic [7:0] balance_channel;
        logic [7:0] state_out;
        logic       all_connected;
    } t_result;

    // 2 + floor(log2(count)), or 2 for a count of 0 or 1
    function automatic logic [3:0] shift_for(input logic [7:0] count);
        logic [3:0] s;
        s = BASE_SHIFT;
        for (int i = 1; i < 8; i++) begin
            if (count[i]) begin
                s = BASE_SHIFT + 4'(i);
            end
        end
        return s;
    endfunction

endpackage

>>> sv/cell_balance_decider_top.sv
// cell balance decider: an accepted input word passes the input and update registers into the result register
// throughput one word per cycle unless the output stalls, stages: input register, average update, result register
// the average accumulator feeds back within the update stage, so reports follow back to back
// presence flags for the tick check are regrouped in a register behind the map
// synchronous active-low reset clears the pipeline, average, presence map and config
// registers reset to count 0, delta 10, start level 0, charging on, shift 2
module cell_balance_decider_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // cell_num[7:0], cell_state[15:8], cell_voltage[31:16]
    input  logic        s_axis_tuser,  // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // balance_on[0], balance_channel[8:1], state_out[16:9], all_connected[17], zero[23:18]
    output logic [23:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    cbd_pkg::t_cfg    r_cfg;
    cbd_pkg::t_item   r_a;
    cbd_pkg::t_item   r_b;
    cbd_pkg::t_result r_out;
    cbd_pkg::t_result n_out;
    logic             r_a_valid;
    logic             r_b_valid;
    logic             r_out_valid;
    logic [31:0]      r_b_avg;
    logic [31:0]      avg_next;
    logic             all_seen;
    logic             out_adv;
    logic             b_adv;
    logic             a_adv;
    logic             in_acc;
    logic             upd;

    assign out_adv = !r_out_valid || m_axis_tready;
    assign b_adv   = r_b_valid && out_adv;
    assign a_adv   = r_a_valid && (!r_b_valid || b_adv);
    assign s_axis_tready = !r_a_valid || a_adv;
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign upd     = a_adv && (r_a.func == cbd_pkg::FUNC_REPORT);

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cell_count    <= 8'd0;
            r_cfg.balance_delta <= 16'sd10;
            r_cfg.start_level   <= 16'sd0;
            r_cfg.charging      <= 1'b1;
            r_cfg.avg_shift     <= cbd_pkg::BASE_SHIFT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                cbd_pkg::REG_CELL_COUNT: begin
                    r_cfg.cell_count <= i_cfg_data[7:0];
                    r_cfg.avg_shift  <= cbd_pkg::shift_for(i_cfg_data[7:0]);
                end
                cbd_pkg::REG_BALANCE_DELTA: begin
                    r_cfg.balance_delta <= i_cfg_data;
                end
                cbd_pkg::REG_START_LEVEL: begin
                    r_cfg.start_level <= i_cfg_data;
                end
                cbd_pkg::REG_CHARGING_MODE: begin
                    r_cfg.charging <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    cbd_avg u_avg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_upd      (upd),
        .i_voltage  (r_a.cell_voltage),
        .i_shift    (r_cfg.avg_shift),
        .o_avg_next (avg_next)
    );

    cbd_seen u_seen (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_set        (upd),
        .i_cell_num   (r_a.cell_num),
        .i_cell_count (r_cfg.cell_count),
        .o_all_seen   (all_seen)
    );

    cbd_decide u_decide (
        .i_cfg      (r_cfg),
        .i_item     (r_b),
        .i_avg      (r_b_avg),
        .i_all_seen (all_seen),
        .o_res      (n_out)
    );

    // pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_a_valid <= s_axis_tvalid;
            end
            if (!r_b_valid || b_adv) begin
                r_b_valid <= a_adv;
            end
            if (out_adv) begin
                r_out_valid <= b_adv;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a.func         <= s_axis_tuser;
            r_a.cell_num     <= s_axis_tdata[7:0];
            r_a.cell_state   <= s_axis_tdata[15:8];
            r_a.cell_voltage <= s_axis_tdata[31:16];
        end
        if (a_adv) begin
            r_b     <= r_a;
            r_b_avg <= avg_next;
        end
        if (b_adv) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out.all_connected, r_out.state_out,
                            r_out.balance_channel, r_out.balance_on};

endmodule

>>> sv/cbd_avg.sv
// running exponential voltage average, updated once per accepted cell report
module cbd_avg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_upd,
    input  logic signed [15:0] i_voltage,
    input  logic [3:0]         i_shift,
    output logic [31:0]        o_avg_next
);

    logic [31:0] r_avg;
    logic [31:0] n_avg;
    logic [31:0] v32;
    logic [31:0] seed;

    always_comb begin
        v32 = 32'(i_voltage);
        // an empty accumulator is seeded with the scaled voltage first
        seed = (r_avg == 32'd0) ? (v32 << i_shift) : r_avg;
        n_avg = seed + (v32 - 32'($signed(seed) >>> i_shift));
    end

    assign o_avg_next = n_avg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg <= '0;
        end else if (i_upd) begin
            r_avg <= n_avg;
        end
    end

endmodule

>>> sv/cbd_seen.sv
// sticky presence map with registered per-group all-seen flags
module cbd_seen (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_set,
    input  logic [7:0] i_cell_num,
    input  logic [7:0] i_cell_count,
    output logic       o_all_seen
);

    logic [cbd_pkg::MAX_CELLS-1:0] r_map;
    logic [cbd_pkg::NUM_GRP-1:0]   r_grp_ok;
    logic [cbd_pkg::NUM_GRP-1:0]   n_grp_ok;
    logic                          r_count_ok;
    logic                          in_range;

    assign in_range = {1'b0, i_cell_num} < cbd_pkg::CMP_W'(cbd_pkg::MAX_CELLS);

    always_comb begin
        for (int g = 0; g < cbd_pkg::NUM_GRP; g++) begin
            n_grp_ok[g] = 1'b1;
            for (int k = 0; k < cbd_pkg::GRP_SIZE; k++) begin
                if (g * cbd_pkg::GRP_SIZE + k < cbd_pkg::MAX_CELLS) begin
                    if (cbd_pkg::CMP_W'(g * cbd_pkg::GRP_SIZE + k) < {1'b0, i_cell_count}
                        && !r_map[g * cbd_pkg::GRP_SIZE + k]) begin
                        n_grp_ok[g] = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map      <= '0;
            r_grp_ok   <= '0;
            r_count_ok <= 1'b0;
        end else begin
            if (i_set && in_range) begin
                r_map[i_cell_num[cbd_pkg::MAP_IDX_W-1:0]] <= 1'b1;
            end
            r_grp_ok   <= n_grp_ok;
            // cells past the map never count as seen
            r_count_ok <= {1'b0, i_cell_count} <= cbd_pkg::CMP_W'(cbd_pkg::MAX_CELLS);
        end
    end

    assign o_all_seen = (&r_grp_ok) && r_count_ok;

endmodule

>>> sv/cbd_decide.sv
// balance decision and result forming from the updated average
module cbd_decide (
    input  cbd_pkg::t_cfg    i_cfg,
    input  cbd_pkg::t_item   i_item,
    input  logic [31:0]      i_avg,
    input  logic             i_all_seen,
    output cbd_pkg::t_result o_res
);

    logic [31:0]        avg_sh;
    logic signed [15:0] avg16;
    logic signed [16:0] thr;
    logic               bal;

    always_comb begin
        avg_sh = 32'($signed(i_avg) >>> i_cfg.avg_shift);
        avg16  = avg_sh[15:0];
        thr    = 17'(avg16) + 17'(i_cfg.balance_delta);
        bal    = i_cfg.charging
                 && (17'(i_item.cell_voltage) >= thr)
                 && (i_item.cell_voltage >= i_cfg.start_level);

        o_res = '0;
        if (i_item.func == cbd_pkg::FUNC_TICK) begin
            o_res.all_connected = i_all_seen;
        end else if (bal) begin
            o_res.balance_on      = 1'b1;
            o_res.balance_channel = i_cfg.cell_count - i_item.cell_num - 8'd1;
            o_res.state_out       = cbd_pkg::BALANCE_STATE;
        end else begin
            o_res.state_out = i_item.cell_state;
        end
    end

endmodule
